// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: sv/nrle_pkg.sv
// ----------------------------------------------------------------------------
// nrle_pkg
// Types and constants of the nibble run-length sprite decoder.
// ----------------------------------------------------------------------------
package nrle_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 512;
    localparam int DEFAULT_MAX_HEIGHT = 256;

    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 9;
    localparam int KEY_W      = 4;
    localparam int COUNT_W    = 4;
    localparam int COLOR_W    = 8;
    localparam int INDEX_W    = 17;
    localparam int CURSOR_W   = 18;
    localparam int SIZE_W     = WIDTH_W + HEIGHT_W;

    localparam logic [COLOR_W-1:0] TRANSPARENT_COLOR = 8'hFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSPARENT_KEY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_ROWS     = 3'd3;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       first_of_cel;
    } code_t;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [COLOR_W-1:0] pixel_color;
        logic               run_end;
        logic               overrun_error;
    } pixel_t;

    // Classified code byte as it travels through the queue.
    typedef struct packed {
        logic               first;
        logic [COUNT_W-1:0] count;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    // Effective configuration seen by the decode engine.
    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [SIZE_W-1:0]   size;
        logic                mirror;
    } geom_t;

endpackage

// File: sv/nibble_rle_sprite_decoder_top.sv
// ----------------------------------------------------------------------------
// nibble_rle_sprite_decoder_top
// Run-length sprite cel decoder: code bytes in, indexed pixel writes out.
// ----------------------------------------------------------------------------
// A byte is written into the queue, popped into the engine's run state, and its first pixel
// is registered into the output register that drives pixel_valid. The decode engine takes
//   a decode step per byte, then a step per pixel; a 4-entry queue lets bytes arrive meanwhile.
// Overrun and dropped bytes take the decode step only.
// Reset clears all control state; the decoder then ignores bytes until one
//   marks first_of_cel. No clearing pass; sizes default to one pixel.
module nibble_rle_sprite_decoder_top
    import nrle_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   code_valid,
    output logic                   code_ready,
    input  code_t                  code,
    output logic                   pixel_valid,
    input  logic                   pixel_ready,
    output pixel_t                 pixel
);

    logic [KEY_W-1:0] key;
    geom_t            geom;
    cmd_t             front_cmd;
    cmd_t             head;
    logic             q_full;
    logic             q_avail;
    logic             q_pop;
    logic             q_push;

    assign code_ready = !q_full;
    assign q_push     = code_valid && code_ready;

    nrle_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key),
        .geom      (geom)
    );

    nrle_front u_front (
        .code (code),
        .key  (key),
        .cmd  (front_cmd)
    );

    nrle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (head)
    );

    nrle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .avail       (q_avail),
        .head        (head),
        .pop         (q_pop),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel)
    );

endmodule

// File: sv/nrle_cfg.sv
// ----------------------------------------------------------------------------
// nrle_cfg
// Configuration registers, size saturation and cel area.
// ----------------------------------------------------------------------------
module nrle_cfg
    import nrle_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [KEY_W-1:0]       key,
    output geom_t                  geom
);

    localparam int WIDTH_CAP  = (MAX_WIDTH  > 1023) ? 1023 : MAX_WIDTH;
    localparam int HEIGHT_CAP = (MAX_HEIGHT > 511)  ? 511  : MAX_HEIGHT;

    logic [KEY_W-1:0]    key_reg;
    logic                mirror_reg;
    logic [WIDTH_W-1:0]  weff_reg;
    logic [HEIGHT_W-1:0] heff_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [WIDTH_W-1:0]  weff_next;
    logic [HEIGHT_W-1:0] heff_next;
    logic [SIZE_W-1:0]   size_next;
    logic [WIDTH_W-1:0]  wr_width;
    logic [HEIGHT_W-1:0] wr_height;

    assign cfg_ready = 1'b1;

    assign wr_width  = cfg_data[WIDTH_W-1:0];
    assign wr_height = cfg_data[HEIGHT_W-1:0];

    // Saturate sizes on the way in.
    always_comb
    begin
        if (wr_width == '0)
            weff_next = WIDTH_W'(1);
        else if (wr_width > WIDTH_CAP[WIDTH_W-1:0])
            weff_next = WIDTH_CAP[WIDTH_W-1:0];
        else
            weff_next = wr_width;

        if (wr_height == '0)
            heff_next = HEIGHT_W'(1);
        else if (wr_height > HEIGHT_CAP[HEIGHT_W-1:0])
            heff_next = HEIGHT_CAP[HEIGHT_W-1:0];
        else
            heff_next = wr_height;
    end

    // Area from the registered sizes keeps the multiplier alone in its path.
    assign size_next = SIZE_W'(weff_reg) * SIZE_W'(heff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            mirror_reg <= 1'b0;
            weff_reg   <= WIDTH_W'(1);
            heff_reg   <= HEIGHT_W'(1);
            size_reg   <= SIZE_W'(1);
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:     weff_reg   <= weff_next;
                    CFG_IMAGE_HEIGHT:    heff_reg   <= heff_next;
                    CFG_TRANSPARENT_KEY: key_reg    <= cfg_data[KEY_W-1:0];
                    CFG_MIRROR_ROWS:     mirror_reg <= cfg_data[0];
                    default:             ;
                endcase
            end
            size_reg <= size_next;
        end
    end

    assign key         = key_reg;
    assign geom.width  = weff_reg;
    assign geom.height = heff_reg;
    assign geom.size   = size_reg;
    assign geom.mirror = mirror_reg;

endmodule

// File: sv/nrle_front.sv
// ----------------------------------------------------------------------------
// nrle_front
// Splits a code byte into run length and color and applies the color key.
// ----------------------------------------------------------------------------
module nrle_front
    import nrle_pkg::*;
(
    input  code_t            code,
    input  logic [KEY_W-1:0] key,
    output cmd_t             cmd
);

    logic [KEY_W-1:0] nibble;

    assign nibble    = code.code_byte[3:0];
    assign cmd.first = code.first_of_cel;
    assign cmd.count = code.code_byte[7:4];
    assign cmd.color = (nibble == key) ? TRANSPARENT_COLOR : COLOR_W'(nibble);

endmodule

// File: sv/nrle_queue.sv
// ----------------------------------------------------------------------------
// nrle_queue
// Short command queue between the front and the decode engine.
// ----------------------------------------------------------------------------
module nrle_queue
    import nrle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t head
);

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;

    assign full  = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign avail = (fill_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

// File: sv/nrle_back.sv
// ----------------------------------------------------------------------------
// nrle_back
// Decode engine: tracks the write cursor and expands runs one pixel a cycle while the pixel output is not stalled.
// ----------------------------------------------------------------------------
module nrle_back
    import nrle_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  geom_t  geom,
    input  logic   avail,
    input  cmd_t   head,
    output logic   pop,
    output logic   pixel_valid,
    input  logic   pixel_ready,
    output pixel_t pixel
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t              state_reg,     state_next;
    logic [CURSOR_W-1:0] cursor_reg,    cursor_next;
    logic [INDEX_W-1:0]  row_start_reg, row_start_next;
    logic [CURSOR_W-1:0] row_end_reg,   row_end_next;
    logic [HEIGHT_W-1:0] rows_reg,      rows_next;
    logic                halted_reg,    halted_next;
    logic [COUNT_W-1:0]  cnt_reg,       cnt_next;
    logic [COLOR_W-1:0]  color_reg,     color_next;
    logic                out_valid_reg, out_valid_next;
    pixel_t              out_reg,       out_next;

    logic                emit_ok;
    logic [CURSOR_W-1:0] cur_e;
    logic [INDEX_W-1:0]  rs_e;
    logic [HEIGHT_W-1:0] rows_e;
    logic                halt_e;
    logic [CURSOR_W-1:0] rend_e;
    logic                past_end;
    logic                overrun;
    logic [CURSOR_W-1:0] cur_inc;
    logic [CURSOR_W-1:0] cur_dec;
    logic [CURSOR_W-1:0] next_row_end;
    logic                row_done;
    logic                last_row;
    logic                last_pix;

    assign emit_ok = !out_valid_reg || pixel_ready;
    assign pop     = (state_reg == ST_IDLE) && avail && emit_ok;

    // Restart values take effect before the byte itself is decoded.
    always_comb
    begin
        if (head.first)
        begin
            cur_e  = geom.mirror ? CURSOR_W'(geom.width) : '0;
            rs_e   = '0;
            rows_e = geom.height;
            halt_e = 1'b0;
        end
        else
        begin
            cur_e  = cursor_reg;
            rs_e   = row_start_reg;
            rows_e = rows_reg;
            halt_e = halted_reg;
        end
    end

    assign rend_e   = CURSOR_W'(rs_e) + CURSOR_W'(geom.width);
    assign past_end = SIZE_W'(cur_e) >= geom.size;
    assign overrun  = (SIZE_W'(cur_e) + SIZE_W'(head.count)) > geom.size;

    assign cur_inc      = cursor_reg + 1'b1;
    assign cur_dec      = cursor_reg - 1'b1;
    assign next_row_end = CURSOR_W'(row_end_reg[INDEX_W-1:0]) + CURSOR_W'(geom.width);
    assign row_done     = (cur_dec == CURSOR_W'(row_start_reg));
    assign last_row     = row_done && (rows_reg == HEIGHT_W'(1));
    assign last_pix     = (cnt_reg == COUNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        row_start_next = row_start_reg;
        row_end_next   = row_end_reg;
        rows_next      = rows_reg;
        halted_next    = halted_reg;
        cnt_next       = cnt_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && !pixel_ready;
        out_next       = out_reg;

        if (pop)
        begin
            cursor_next    = cur_e;
            row_start_next = rs_e;
            rows_next      = rows_e;
            halted_next    = halt_e;
            cnt_next       = head.count;
            color_next     = head.color;

            priority if (halt_e)
            begin
                // drop the byte
            end
            else if (!geom.mirror)
            begin
                priority if (past_end)
                    halted_next = 1'b1;
                else if (overrun)
                begin
                    out_valid_next        = 1'b1;
                    out_next.pixel_index  = cur_e[INDEX_W-1:0];
                    out_next.pixel_color  = '0;
                    out_next.run_end      = 1'b1;
                    out_next.overrun_error = 1'b1;
                    halted_next           = 1'b1;
                end
                else if (head.count != '0)
                    state_next = ST_RUN;
                else
                begin
                    // zero run: nothing to emit
                end
            end
            else
            begin
                if (rows_e == '0)
                    halted_next = 1'b1;
                else
                begin
                    row_end_next = rend_e;
                    // Pull a cursor that left the row back to its right end.
                    if (cur_e <= CURSOR_W'(rs_e) || cur_e > rend_e)
                        cursor_next = rend_e;
                    if (head.count != '0)
                        state_next = ST_RUN;
                end
            end
        end
        else if (state_reg == ST_RUN && emit_ok)
        begin
            out_valid_next         = 1'b1;
            out_next.pixel_color   = color_reg;
            out_next.overrun_error = 1'b0;
            cnt_next               = cnt_reg - 1'b1;
            if (!geom.mirror)
            begin
                out_next.pixel_index = cursor_reg[INDEX_W-1:0];
                out_next.run_end     = last_pix;
                cursor_next          = cur_inc;
                if (last_pix)
                begin
                    state_next = ST_IDLE;
                    if (SIZE_W'(cur_inc) >= geom.size)
                        halted_next = 1'b1;
                end
            end
            else
            begin
                out_next.pixel_index = cur_dec[INDEX_W-1:0];
                out_next.run_end     = last_pix || last_row;
                cursor_next          = cur_dec;
                if (row_done)
                begin
                    rows_next      = rows_reg - 1'b1;
                    row_start_next = row_end_reg[INDEX_W-1:0];
                    row_end_next   = next_row_end;
                    cursor_next    = next_row_end;
                end
                if (last_row)
                    halted_next = 1'b1;
                if (last_pix || last_row)
                    state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            row_start_reg <= '0;
            row_end_reg   <= '0;
            rows_reg      <= '0;
            halted_reg    <= 1'b1;
            cnt_reg       <= '0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            row_start_reg <= row_start_next;
            row_end_reg   <= row_end_next;
            rows_reg      <= rows_next;
            halted_reg    <= halted_next;
            cnt_reg       <= cnt_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

endmodule

// File: sv/nrle_checker.sv
// ----------------------------------------------------------------------------
// nrle_checker
// Port-level checks on the pixel channel of the decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nrle_checker
    import nrle_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   pixel_valid,
    input logic   pixel_ready,
    input pixel_t pixel
);

    // hold a stalled transaction
    `ASSERT_NEXT(a_pixel_hold, pixel_valid && !pixel_ready, pixel_valid && $stable(pixel))

    // an overrun result closes the byte and carries no color
    `ASSERT_SAME(a_overrun_shape, pixel_valid && pixel.overrun_error, pixel.run_end && (pixel.pixel_color == '0))

    // colors are a nibble or the transparent code
    `ASSERT_SAME(a_color_range, pixel_valid, (pixel.pixel_color[7:4] == 4'h0) || (pixel.pixel_color == TRANSPARENT_COLOR))

endmodule

bind nibble_rle_sprite_decoder_top nrle_checker u_nrle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
);
